// ----- src/ellipse_bounding_box_clip_top_assert.svh -----
// assertion macros for the ellipse bounding box block
// included by the top level; no other dependencies
`ifndef ELLIPSE_BOUNDING_BOX_CLIP_TOP_ASSERT_SVH
`define ELLIPSE_BOUNDING_BOX_CLIP_TOP_ASSERT_SVH

// same-cycle implication
`define EBBC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ebbc assertion failed");

// next-cycle implication
`define EBBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ebbc assertion failed");

`endif

// ----- src/ebbc_pkg.sv -----
// shared types and constants for the ellipse bounding box block
// no dependencies
package ebbc_pkg;

   localparam int DIV_STEPS  = 32;
   localparam int SQRT_STEPS = 16;

   localparam logic [17:0] ANG_HALF_TURN    = 18'd23040;
   localparam logic [17:0] ANG_QUARTER_TURN = 18'd11520;
   localparam logic [18:0] ANG_BIAS         = 19'd69120;

   typedef enum logic [1:0] {
      EXT_CALC,
      EXT_DIRECT,
      EXT_SWAP,
      EXT_ZERO
   } ext_sel_type;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        axis_w;
      logic [15:0]        axis_h;
      ext_sel_type        sel;
      logic               degen;
   } side_type;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT
   } csr_index_type;

   // atan(2^-i) in 2^-21 degree
   function automatic logic [26:0] atan_val(input int idx);
      logic [26:0] v;
      case (idx)
         0:  v = 27'd94371840;
         1:  v = 27'd55710950;
         2:  v = 27'd29436136;
         3:  v = 27'd14942242;
         4:  v = 27'd7500117;
         5:  v = 27'd3753715;
         6:  v = 27'd1877315;
         7:  v = 27'd938715;
         8:  v = 27'd469365;
         9:  v = 27'd234683;
         10: v = 27'd117342;
         11: v = 27'd58671;
         12: v = 27'd29335;
         13: v = 27'd14668;
         14: v = 27'd7334;
         15: v = 27'd3667;
         16: v = 27'd1833;
         17: v = 27'd917;
         18: v = 27'd458;
         19: v = 27'd229;
         20: v = 27'd115;
         21: v = 27'd57;
         22: v = 27'd29;
         23: v = 27'd14;
         default: v = 27'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- src/ebbc_if.sv -----
// request and response channel interfaces of the ellipse bounding box block
// no dependencies
interface ebbc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] center_x;
   logic signed [15:0] center_y;
   logic [15:0]        axis_width;
   logic [15:0]        axis_height;
   logic signed [16:0] angle_deg;

   modport source (output valid, center_x, center_y, axis_width, axis_height, angle_deg,
                   input ready);
   modport sink (input valid, center_x, center_y, axis_width, axis_height, angle_deg,
                 output ready);
endinterface

interface ebbc_rsp_if;
   logic               valid;
   logic               ready;
   logic [10:0]        box_left;
   logic [10:0]        box_top;
   logic signed [13:0] box_width;
   logic signed [13:0] box_height;
   logic               degenerate;

   modport source (output valid, box_left, box_top, box_width, box_height, degenerate,
                   input ready);
   modport sink (input valid, box_left, box_top, box_width, box_height, degenerate,
                 output ready);
endinterface

// ----- src/ellipse_bounding_box_clip_top.sv -----
// Axis-aligned bounding box of a rotated ellipse, clipped to the image.
// Request channel req_if carries one ellipse per beat: centre and full axes in
// Q12.4 pixels, angle in 1/128 degree. Response channel rsp_if returns one box
// per request beat, in order: left and top floored at zero, width and height
// trimmed at the right and bottom image edges, and a degenerate flag for a
// zero axis. The csr_ port writes image_width (index 0) and image_height
// (index 1); write only while no beat is in flight.
// The pipeline from request beat to response beat has one stage of angle
// folding, one per CORDIC step, three of squaring, multiplying and summing,
// 32 of the bit-per-stage divider, 16 of the bit-per-stage square root, and
// two of box arithmetic and clipping. A new request beat is taken every cycle
// while no stalled response freezes the pipeline; throughput is one beat per cycle.
// Reset clears all valid bits and loads image 640 x 480.
// When the receiver holds rsp_if.ready low with a beat waiting, the whole
// pipeline freezes and req_if.ready drops; nothing is lost or repeated.
// Depends on ebbc_pkg, ebbc_if and the assertion macro header.
`include "ellipse_bounding_box_clip_top_assert.svh"

module ellipse_bounding_box_clip_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ebbc_req_if.sink    req_if,
   ebbc_rsp_if.source  rsp_if,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import ebbc_pkg::*;

   localparam int ST_COR  = 1;
   localparam int ST_SQ   = ST_COR + CORDIC_STEPS;
   localparam int ST_MUL  = ST_SQ + 1;
   localparam int ST_SUM  = ST_MUL + 1;
   localparam int ST_DIV  = ST_SUM + 1;
   localparam int ST_SQRT = ST_DIV + DIV_STEPS;
   localparam int NSTAGE  = ST_SQRT + SQRT_STEPS;

   function automatic logic [61:0] div_step(input logic [61:0] acc, input logic [29:0] n);
      logic [30:0] t;
      logic [30:0] diff;
      logic        ge;
      t    = {acc[61:32], acc[31]};
      ge   = (t >= {1'b0, n});
      diff = t - {1'b0, n};
      return {(ge ? diff[29:0] : t[29:0]), acc[30:0], ge};
   endfunction

   function automatic logic [35:0] sqrt_step(input logic [19:0] rem, input logic [15:0] root,
                                             input logic [1:0] pair);
      logic [19:0] rs;
      logic [19:0] trial;
      logic        ge;
      rs    = {rem[17:0], pair};
      trial = {2'b00, root, 2'b01};
      ge    = (rs >= trial);
      return {(ge ? rs - trial : rs), root[14:0], ge};
   endfunction

   function automatic logic [13:0] trunc_px(input logic signed [20:0] v);
      logic [20:0] mag;
      logic [20:0] sh;
      mag = v[20] ? 21'(-v) : v;
      sh  = mag >> 5;
      return v[20] ? 14'(-sh) : sh[13:0];
   endfunction

   // configuration
   logic [11:0] image_width_ff, image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 12'd640;
         image_height_ff <= 12'd480;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance: the pipeline moves unless a waiting response is stalled
   logic en;
   logic rsp_valid_ff;
   assign en = !(rsp_valid_ff && !rsp_if.ready);
   assign req_if.ready = en;

   // angle folding into [0, quarter turn] and special case selection
   logic [13:0] red_t_in, red_t_ff;
   side_type    red_side_in;

   always_comb begin
      logic signed [18:0] vs;
      logic [17:0]        v;
      logic [17:0]        t0;
      logic [17:0]        tf;
      vs = {{2{req_if.angle_deg[16]}}, req_if.angle_deg} + $signed(ANG_BIAS);
      v  = vs[17:0];
      if (v >= 18'(5 * ANG_HALF_TURN))      t0 = v - 18'(5 * ANG_HALF_TURN);
      else if (v >= 18'(4 * ANG_HALF_TURN)) t0 = v - 18'(4 * ANG_HALF_TURN);
      else if (v >= 18'(3 * ANG_HALF_TURN)) t0 = v - 18'(3 * ANG_HALF_TURN);
      else if (v >= 18'(2 * ANG_HALF_TURN)) t0 = v - 18'(2 * ANG_HALF_TURN);
      else if (v >= ANG_HALF_TURN)          t0 = v - ANG_HALF_TURN;
      else                                  t0 = v;
      tf = (t0 > ANG_QUARTER_TURN) ? ANG_HALF_TURN - t0 : t0;
      red_t_in = tf[13:0];
      red_side_in.center_x = req_if.center_x;
      red_side_in.center_y = req_if.center_y;
      red_side_in.axis_w   = req_if.axis_width;
      red_side_in.axis_h   = req_if.axis_height;
      red_side_in.degen    = (req_if.axis_width == 16'd0) || (req_if.axis_height == 16'd0);
      if (red_side_in.degen)                              red_side_in.sel = EXT_ZERO;
      else if (req_if.axis_width == req_if.axis_height)   red_side_in.sel = EXT_DIRECT;
      else if (tf == 18'd0)                               red_side_in.sel = EXT_DIRECT;
      else if (tf == ANG_QUARTER_TURN)                    red_side_in.sel = EXT_SWAP;
      else                                                red_side_in.sel = EXT_CALC;
   end

   always_ff @(posedge clock) begin
      if (en) red_t_ff <= red_t_in;
   end

   // valid bits and side data travel along every stage
   logic     valid_ff [NSTAGE];
   side_type side_ff  [NSTAGE];

   for (genvar s = 0; s < NSTAGE; s++) begin : g_line
      logic     valid_in;
      side_type side_in;
      if (s == 0) begin : g_first
         assign valid_in = req_if.valid;
         assign side_in  = red_side_in;
      end else begin : g_rest
         assign valid_in = valid_ff[s-1];
         assign side_in  = side_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (reset) valid_ff[s] <= 1'b0;
         else if (en) valid_ff[s] <= valid_in;
      end
      always_ff @(posedge clock) begin
         if (en) side_ff[s] <= side_in;
      end
   end

   // rotation-mode cordic, one step per stage
   logic signed [31:0] cor_x_ff [CORDIC_STEPS];
   logic signed [31:0] cor_y_ff [CORDIC_STEPS];
   logic signed [29:0] cor_z_ff [CORDIC_STEPS];

   for (genvar c = 0; c < CORDIC_STEPS; c++) begin : g_cordic
      logic signed [31:0] px, py, x_in, y_in;
      logic signed [29:0] pz, z_in, at;
      if (c == 0) begin : g_first
         assign px = 32'sd268435456;
         assign py = 32'sd0;
         assign pz = $signed({2'b00, red_t_ff, 14'd0});
      end else begin : g_rest
         assign px = cor_x_ff[c-1];
         assign py = cor_y_ff[c-1];
         assign pz = cor_z_ff[c-1];
      end
      assign at = $signed({3'b000, atan_val(c)});
      always_comb begin
         if (!pz[29]) begin
            x_in = px - (py >>> c);
            y_in = py + (px >>> c);
            z_in = pz - at;
         end else begin
            x_in = px + (py >>> c);
            y_in = py - (px >>> c);
            z_in = pz + at;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            cor_x_ff[c] <= x_in;
            cor_y_ff[c] <= y_in;
            cor_z_ff[c] <= z_in;
         end
      end
   end

   // squares of the cordic outputs and the axes
   logic [29:0] cc_ff, ss_ff, cc_in, ss_in;
   logic [31:0] a2_ff, b2_ff, a2_in, b2_in;

   always_comb begin
      logic signed [17:0] xr, yr;
      logic signed [35:0] xx, yy;
      xr = cor_x_ff[CORDIC_STEPS-1][31:14];
      yr = cor_y_ff[CORDIC_STEPS-1][31:14];
      xx = xr * xr;
      yy = yr * yr;
      cc_in = xx[29:0];
      ss_in = yy[29:0];
      a2_in = {16'd0, side_ff[ST_SQ-1].axis_w} * {16'd0, side_ff[ST_SQ-1].axis_w};
      b2_in = {16'd0, side_ff[ST_SQ-1].axis_h} * {16'd0, side_ff[ST_SQ-1].axis_h};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cc_ff <= cc_in;
         ss_ff <= ss_in;
         a2_ff <= a2_in;
         b2_ff <= b2_in;
      end
   end

   // weighted products
   logic [61:0] pxa_ff, pxb_ff, pya_ff, pyb_ff;
   logic [29:0] n_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pxa_ff <= {30'd0, a2_ff} * {32'd0, cc_ff};
         pxb_ff <= {30'd0, b2_ff} * {32'd0, ss_ff};
         pya_ff <= {30'd0, a2_ff} * {32'd0, ss_ff};
         pyb_ff <= {30'd0, b2_ff} * {32'd0, cc_ff};
         n_ff   <= cc_ff + ss_ff;
      end
   end

   // numerators and divisor
   logic [61:0] numx_ff, numy_ff;
   logic [29:0] nd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         numx_ff <= pxa_ff + pxb_ff;
         numy_ff <= pya_ff + pyb_ff;
         nd_ff   <= (n_ff == 30'd0) ? 30'd1 : n_ff;
      end
   end

   // restoring divider, one quotient bit per stage, two lanes
   logic [61:0] div_x_ff [DIV_STEPS];
   logic [61:0] div_y_ff [DIV_STEPS];
   logic [29:0] div_n_ff [DIV_STEPS];

   for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
      logic [61:0] ax, ay;
      logic [29:0] an;
      if (d == 0) begin : g_first
         assign ax = numx_ff;
         assign ay = numy_ff;
         assign an = nd_ff;
      end else begin : g_rest
         assign ax = div_x_ff[d-1];
         assign ay = div_y_ff[d-1];
         assign an = div_n_ff[d-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            div_x_ff[d] <= div_step(ax, an);
            div_y_ff[d] <= div_step(ay, an);
            div_n_ff[d] <= an;
         end
      end
   end

   // digit-by-digit square root, one root bit per stage
   logic [19:0] sq_rem_x_ff  [SQRT_STEPS];
   logic [19:0] sq_rem_y_ff  [SQRT_STEPS];
   logic [15:0] sq_root_x_ff [SQRT_STEPS];
   logic [15:0] sq_root_y_ff [SQRT_STEPS];
   logic [31:0] sq_val_x_ff  [SQRT_STEPS-1];
   logic [31:0] sq_val_y_ff  [SQRT_STEPS-1];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam int HI = 31 - 2 * k;
      logic [31:0] vx, vy;
      logic [19:0] rx, ry;
      logic [15:0] qx, qy;
      logic [35:0] step_x_in, step_y_in;
      if (k == 0) begin : g_first
         assign vx = div_x_ff[DIV_STEPS-1][31:0];
         assign vy = div_y_ff[DIV_STEPS-1][31:0];
         assign rx = 20'd0;
         assign ry = 20'd0;
         assign qx = 16'd0;
         assign qy = 16'd0;
      end else begin : g_rest
         assign vx = sq_val_x_ff[k-1];
         assign vy = sq_val_y_ff[k-1];
         assign rx = sq_rem_x_ff[k-1];
         assign ry = sq_rem_y_ff[k-1];
         assign qx = sq_root_x_ff[k-1];
         assign qy = sq_root_y_ff[k-1];
      end
      assign step_x_in = sqrt_step(rx, qx, vx[HI -: 2]);
      assign step_y_in = sqrt_step(ry, qy, vy[HI -: 2]);
      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_x_ff[k]  <= step_x_in[35:16];
            sq_root_x_ff[k] <= step_x_in[15:0];
            sq_rem_y_ff[k]  <= step_y_in[35:16];
            sq_root_y_ff[k] <= step_y_in[15:0];
         end
      end
      if (k < SQRT_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               sq_val_x_ff[k] <= vx;
               sq_val_y_ff[k] <= vy;
            end
         end
      end
   end

   // box arithmetic in 1/32 pixel
   logic               f1_valid_ff, f1_degen_ff;
   logic [15:0]        ex_ff, ey_ff, ex_in, ey_in;
   logic signed [19:0] left_ff, top_ff, w_ff, h_ff;
   side_type           fs;

   assign fs = side_ff[NSTAGE-1];

   always_comb begin
      case (fs.sel)
         EXT_ZERO: begin
            ex_in = 16'd0;
            ey_in = 16'd0;
         end
         EXT_DIRECT: begin
            ex_in = fs.axis_w;
            ey_in = fs.axis_h;
         end
         EXT_SWAP: begin
            ex_in = fs.axis_h;
            ey_in = fs.axis_w;
         end
         default: begin
            ex_in = sq_root_x_ff[SQRT_STEPS-1];
            ey_in = sq_root_y_ff[SQRT_STEPS-1];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) f1_valid_ff <= 1'b0;
      else if (en) f1_valid_ff <= valid_ff[NSTAGE-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_degen_ff <= fs.degen;
         ex_ff       <= ex_in;
         ey_ff       <= ey_in;
         left_ff     <= $signed({{3{fs.center_x[15]}}, fs.center_x, 1'b0})
                        - $signed({4'd0, ex_in});
         top_ff      <= $signed({{3{fs.center_y[15]}}, fs.center_y, 1'b0})
                        - $signed({4'd0, ey_in});
         w_ff        <= $signed({3'd0, ex_in, 1'b0}) + 20'sd32;
         h_ff        <= $signed({3'd0, ey_in, 1'b0}) + 20'sd32;
      end
   end

   // clipping and pixel conversion into the output register
   logic [10:0]        box_left_ff, box_top_ff;
   logic [13:0]        box_width_ff, box_height_ff;
   logic               degen_out_ff;
   logic signed [20:0] wc_in, hc_in;

   always_comb begin
      logic signed [20:0] lx, ly, lim_x, lim_y;
      lx    = {left_ff[19], left_ff};
      ly    = {top_ff[19], top_ff};
      lim_x = $signed({4'd0, image_width_ff, 5'd0});
      lim_y = $signed({4'd0, image_height_ff, 5'd0});
      wc_in = (lx + $signed({w_ff[19], w_ff}) > lim_x) ? lim_x - lx : {w_ff[19], w_ff};
      hc_in = (ly + $signed({h_ff[19], h_ff}) > lim_y) ? lim_y - ly : {h_ff[19], h_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= f1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         box_left_ff   <= (left_ff > 20'sd0) ? left_ff[15:5] : 11'd0;
         box_top_ff    <= (top_ff > 20'sd0) ? top_ff[15:5] : 11'd0;
         box_width_ff  <= trunc_px(wc_in);
         box_height_ff <= trunc_px(hc_in);
         degen_out_ff  <= f1_degen_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.box_left   = box_left_ff;
   assign rsp_if.box_top    = box_top_ff;
   assign rsp_if.box_width  = $signed(box_width_ff);
   assign rsp_if.box_height = $signed(box_height_ff);
   assign rsp_if.degenerate = degen_out_ff;

   `EBBC_ASSERT_NEXT(a_req_enters, clock, reset, req_if.valid && req_if.ready, valid_ff[0])
   `EBBC_ASSERT_IMP(a_div_rem, clock, reset, valid_ff[ST_SQRT-1],
                    div_x_ff[DIV_STEPS-1][61:32] < div_n_ff[DIV_STEPS-1])
   `EBBC_ASSERT_IMP(a_sqrt_rem, clock, reset, valid_ff[NSTAGE-1],
                    sq_rem_x_ff[SQRT_STEPS-1] <= {3'd0, sq_root_x_ff[SQRT_STEPS-1], 1'b0})
   `EBBC_ASSERT_IMP(a_degen_zero, clock, reset, f1_valid_ff && f1_degen_ff,
                    (ex_ff == 16'd0) && (ey_ff == 16'd0))

endmodule
